FILE: rtl/core/bmhq_pkg.sv
// Package for the binary min-heap queue: shared widths, command and
// status codes, and the per-cycle operation broadcast to the cell chain.
// No dependencies.
`default_nettype none

package bmhq_pkg;

  localparam int KEY_W        = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 7;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic signed [KEY_W-1:0] key_t;

  // Operation applied by every cell in the same cycle
  typedef struct packed {
    logic en;
    cmd_t cmd;
    key_t key;
  } op_t;

endpackage

`default_nettype wire

FILE: rtl/core/bmhq_in_if.sv
// Command channel of the heap queue: valid/ready handshake carrying the
// command and the key. Depends on bmhq_pkg.
`default_nettype none

interface bmhq_in_if;
  logic           valid;
  logic           ready;
  bmhq_pkg::cmd_t cmd;
  bmhq_pkg::key_t key_in;

  modport source (output valid, output cmd, output key_in, input ready);
  modport sink   (input valid, input cmd, input key_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bmhq_out_if.sv
// Result channel of the heap queue: valid/ready handshake carrying the
// status, the removed key and the new count. Depends on bmhq_pkg.
`default_nettype none

interface bmhq_out_if;
  logic                          valid;
  logic                          ready;
  bmhq_pkg::status_t             status;
  bmhq_pkg::key_t                removed_key;
  logic [bmhq_pkg::COUNT_W-1:0]  count_after;

  modport source (output valid, output status, output removed_key, output count_after,
                  input ready);
  modport sink   (input valid, input status, input removed_key, input count_after,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bmhq_cell.sv
// One cell of the sorted key chain: holds the key at a fixed rank and
// shifts with its neighbors on insert and remove. Depends on bmhq_pkg.
`default_nettype none

module bmhq_cell #(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  wire logic            clk,
  input  wire bmhq_pkg::op_t   op,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic            prev_le,
  input  wire bmhq_pkg::key_t  prev_key,
  input  wire bmhq_pkg::key_t  next_key,
  output bmhq_pkg::key_t       key_r,
  output logic                 le
);

  localparam logic [CNT_W-1:0] IDX = INDEX[CNT_W-1:0];

  bmhq_pkg::key_t key_nxt;
  logic           occ;

  // Occupied ranks form a prefix of the chain
  assign occ = (count > IDX);
  assign le  = occ && (key_r <= op.key);

  // Keep on no-op or when the new key sorts after; otherwise shift
  always_comb begin
    key_nxt = key_r;
    if (op.en) begin
      case (op.cmd)
        bmhq_pkg::CMD_INSERT: begin
          if (!le) begin
            key_nxt = prev_le ? op.key : prev_key;
          end
        end
        bmhq_pkg::CMD_REMOVE: begin
          key_nxt = next_key;
        end
        default: key_nxt = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/binary_min_heap_queue.sv
// Min priority queue of signed 32-bit keys kept as a sorted chain of cells.
// Each result is registered and valid in the cycle after its command.
// One command per cycle unless out_ch stalls; each cell compares and
// shifts once. Reset clears the key count and the output valid; cell
// keys are not cleared, since only ranks below the count are ever read.
// Depends on bmhq_pkg, bmhq_in_if, bmhq_out_if and bmhq_cell.
`default_nettype none

module binary_min_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bmhq_in_if.sink     in_ch,
  bmhq_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CAPACITY[CNT_W-1:0];
  localparam logic [CNT_W-1:0] ONE_CNT = {{(CNT_W-1){1'b0}}, 1'b1};

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  bmhq_pkg::status_t    status_r, status_nxt;
  bmhq_pkg::key_t       removed_r, removed_nxt;
  logic [bmhq_pkg::COUNT_W-1:0] count_after_r, count_after_nxt;
  logic [CNT_W+bmhq_pkg::COUNT_W-1:0] count_wide;

  logic           accept;
  logic           full;
  logic           empty;
  bmhq_pkg::op_t  op;

  bmhq_pkg::key_t cell_key [CAPACITY];
  logic           le_chain [CAPACITY+1];

  // Accept while the result register is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CAP_CNT);
  assign empty       = (count_r == '0);

  // Broadcast the operation only when it changes the chain
  always_comb begin
    op.cmd = in_ch.cmd;
    op.key = in_ch.key_in;
    op.en  = accept && (((in_ch.cmd == bmhq_pkg::CMD_INSERT) && !full) ||
                        ((in_ch.cmd == bmhq_pkg::CMD_REMOVE) && !empty));
  end

  // Rank zero always sees "new key goes here" from its left
  assign le_chain[0] = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bmhq_pkg::key_t prev_key;
    bmhq_pkg::key_t next_key;

    if (i == 0) begin : g_first
      assign prev_key = in_ch.key_in;
    end else begin : g_mid
      assign prev_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key = cell_key[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
    end

    bmhq_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .op       (op),
      .count    (count_r),
      .prev_le  (le_chain[i]),
      .prev_key (prev_key),
      .next_key (next_key),
      .key_r    (cell_key[i]),
      .le       (le_chain[i+1])
    );
  end

  // Next count, result fields and output valid
  always_comb begin
    count_nxt   = count_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    if (op.en) begin
      count_nxt = (op.cmd == bmhq_pkg::CMD_INSERT) ? (count_r + ONE_CNT)
                                                   : (count_r - ONE_CNT);
    end
    if (accept) begin
      status_nxt  = bmhq_pkg::ST_DONE;
      removed_nxt = '0;
      case (in_ch.cmd)
        bmhq_pkg::CMD_INSERT: begin
          if (full) begin
            status_nxt = bmhq_pkg::ST_FULL;
          end
        end
        bmhq_pkg::CMD_REMOVE: begin
          if (empty) begin
            status_nxt = bmhq_pkg::ST_EMPTY;
          end else begin
            removed_nxt = cell_key[0];
          end
        end
        default: status_nxt = bmhq_pkg::ST_DONE;
      endcase
    end
    count_wide      = {{bmhq_pkg::COUNT_W{1'b0}}, count_nxt};
    count_after_nxt = accept ? count_wide[bmhq_pkg::COUNT_W-1:0] : count_after_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    status_r      <= status_nxt;
    removed_r     <= removed_nxt;
    count_after_r <= count_after_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.removed_key = removed_r;
  assign out_ch.count_after = count_after_r;

endmodule

`default_nettype wire

FILE: test/bmhq_checker.sv
// Scoreboard for the binary min-heap queue: watches both channels, keeps a
// heap of its own to predict each result and compares it field by field.
// Depends on bmhq_pkg.

module bmhq_checker #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  bmhq_pkg::cmd_t                in_cmd,
  input  bmhq_pkg::key_t                in_key,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  bmhq_pkg::status_t             out_status,
  input  bmhq_pkg::key_t                out_removed_key,
  input  logic [bmhq_pkg::COUNT_W-1:0]  out_count_after,
  output int                            error_count,
  output int                            pending_count
);

  typedef struct {
    bmhq_pkg::status_t            status;
    bmhq_pkg::key_t               removed_key;
    logic [bmhq_pkg::COUNT_W-1:0] count_after;
  } heap_result_t;

  bmhq_pkg::key_t heap_keys [CAPACITY];
  int             heap_size;
  heap_result_t   queued_results [$];

  initial begin
    error_count   = 0;
    pending_count = 0;
    heap_size     = 0;
  end

  // Apply one command to the shadow heap and work out its result
  task automatic apply_heap_cmd(input bmhq_pkg::cmd_t cmd, input bmhq_pkg::key_t key,
                                output heap_result_t res);
    int             pos;
    int             parent;
    int             left;
    int             pick;
    bmhq_pkg::key_t tmp;
    res.status      = bmhq_pkg::ST_DONE;
    res.removed_key = '0;
    if (cmd == bmhq_pkg::CMD_INSERT) begin
      if (heap_size >= CAPACITY) begin
        res.status = bmhq_pkg::ST_FULL;
      end else begin
        heap_keys[heap_size] = key;
        pos = heap_size;
        heap_size++;
        // sift up while strictly smaller than the parent
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!(heap_keys[pos] < heap_keys[parent])) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[parent];
          heap_keys[parent] = tmp;
          pos = parent;
        end
      end
    end else begin
      if (heap_size == 0) begin
        res.status = bmhq_pkg::ST_EMPTY;
      end else begin
        res.removed_key = heap_keys[0];
        heap_size--;
        if (heap_size > 0) begin
          heap_keys[0] = heap_keys[heap_size];
          pos = 0;
          // sift down toward the smaller child; left wins a tie
          while (1) begin
            left = 2 * pos + 1;
            if (left >= heap_size) break;
            pick = left;
            if (left + 1 < heap_size && heap_keys[left + 1] < heap_keys[left]) pick = left + 1;
            if (!(heap_keys[pick] < heap_keys[pos])) break;
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[pick];
            heap_keys[pick] = tmp;
            pos = pick;
          end
        end
      end
    end
    res.count_after = heap_size[bmhq_pkg::COUNT_W-1:0];
  endtask

  // Predict on each command transaction, then check each result transaction
  always @(posedge clk) begin
    heap_result_t predicted;
    heap_result_t oldest;
    if (!rst_n) begin
      heap_size = 0;
      queued_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        apply_heap_cmd(in_cmd, in_key, predicted);
        queued_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (queued_results.size() == 0) begin
          $error("result transaction with no command waiting for it");
          error_count++;
        end else begin
          oldest = queued_results.pop_front();
          if (out_status !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, out_status);
            error_count++;
          end
          if (out_removed_key !== oldest.removed_key) begin
            $error("removed_key: expected %0d, actual %0d", oldest.removed_key,
                   out_removed_key);
            error_count++;
          end
          if (out_count_after !== oldest.count_after) begin
            $error("count_after: expected %0d, actual %0d", oldest.count_after,
                   out_count_after);
            error_count++;
          end
        end
      end
    end
    pending_count = queued_results.size();
  end

endmodule

FILE: test/tb_binary_min_heap_queue.sv
// Top of the heap queue testbench: clock, reset, command stimulus with bursts
// and a stalling receiver. Depends on bmhq_pkg, both channel interfaces,
// binary_min_heap_queue and bmhq_checker.

module tb_binary_min_heap_queue;

  localparam int CLK_PERIOD   = 12;
  localparam int CAPACITY     = bmhq_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1400;

  logic clk = 1'b0;
  logic rst_n;
  int   error_count;
  int   pending_count;
  int   sent_count;
  int   burst_left;
  int   gap_len;
  int   phase_kind;
  int   phase_len;
  int   insert_pct;
  int   ready_mode;
  int   ready_span;
  int   stall_left;

  bmhq_in_if  in_ch ();
  bmhq_out_if out_ch ();

  binary_min_heap_queue #(.CAPACITY(CAPACITY)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bmhq_checker #(.CAPACITY(CAPACITY)) heap_scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_cmd          (in_ch.cmd),
    .in_key          (in_ch.key_in),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_removed_key (out_ch.removed_key),
    .out_count_after (out_ch.count_after),
    .error_count     (error_count),
    .pending_count   (pending_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mix of clustered values for ties, the extremes and full-range keys
  function automatic bmhq_pkg::key_t rand_key();
    case ($urandom_range(0, 5))
      0: rand_key = bmhq_pkg::key_t'($signed($urandom_range(0, 8)) - 4);
      1: begin
        case ($urandom_range(0, 3))
          0: rand_key = 32'sh8000_0000;
          1: rand_key = 32'sh7FFF_FFFF;
          2: rand_key = '0;
          default: rand_key = '1;
        endcase
      end
      default: rand_key = bmhq_pkg::key_t'($urandom);
    endcase
  endfunction

  // Drive one command and hold it until the transaction completes
  task automatic send_command(input bmhq_pkg::cmd_t cmd, input bmhq_pkg::key_t key);
    @(negedge clk);
    in_ch.valid  = 1'b1;
    in_ch.cmd    = cmd;
    in_ch.key_in = key;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  // Drop valid for a number of cycles, with junk on the payload
  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_ch.valid  = 1'b0;
      in_ch.cmd    = bmhq_pkg::cmd_t'($urandom_range(0, 1));
      in_ch.key_in = bmhq_pkg::key_t'($urandom);
    end
  endtask

  // Hold off until every predicted result has come back
  task automatic drain_results();
    pause_sender(1);
    while (pending_count != 0) @(negedge clk);
  endtask

  // Receiver: ready patterns that change every so often
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      ready_mode = $urandom_range(0, 2);
      ready_span = $urandom_range(16, 160);
      repeat (ready_span) begin
        @(negedge clk);
        case (ready_mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = 1'($urandom_range(0, 1));
          default: begin
            if (stall_left > 0) begin
              out_ch.ready = 1'b0;
              stall_left--;
            end else begin
              out_ch.ready = 1'b1;
              if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 20);
            end
          end
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.cmd    = bmhq_pkg::CMD_INSERT;
    in_ch.key_in = '0;
    sent_count   = 0;
    rst_n        = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: remove on empty, extremes, ties, drain past empty
    send_command(bmhq_pkg::CMD_REMOVE, '0);
    send_command(bmhq_pkg::CMD_INSERT, '0);
    send_command(bmhq_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
    send_command(bmhq_pkg::CMD_INSERT, 32'sh8000_0000);
    send_command(bmhq_pkg::CMD_INSERT, '1);
    send_command(bmhq_pkg::CMD_INSERT, 32'sd1);
    send_command(bmhq_pkg::CMD_INSERT, '0);
    send_command(bmhq_pkg::CMD_INSERT, '1);
    send_command(bmhq_pkg::CMD_INSERT, 32'sd5);
    repeat (9) send_command(bmhq_pkg::CMD_REMOVE, bmhq_pkg::key_t'($urandom));
    send_command(bmhq_pkg::CMD_INSERT, -32'sd7);
    send_command(bmhq_pkg::CMD_INSERT, 32'sd3);
    send_command(bmhq_pkg::CMD_INSERT, -32'sd7);
    repeat (3) send_command(bmhq_pkg::CMD_REMOVE, '1);
    drain_results();

    // Random: fill, drain and mixed phases, sent in bursts
    sent_count = 0;
    burst_left = $urandom_range(1, 32);
    while (sent_count < RANDOM_ITEMS) begin
      phase_kind = $urandom_range(0, 2);
      phase_len  = $urandom_range(40, 140);
      case (phase_kind)
        0: insert_pct = 90;
        1: insert_pct = 10;
        default: insert_pct = 50;
      endcase
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < insert_pct) begin
          send_command(bmhq_pkg::CMD_INSERT, rand_key());
        end else begin
          send_command(bmhq_pkg::CMD_REMOVE, bmhq_pkg::key_t'($urandom));
        end
        burst_left--;
        if (burst_left == 0) begin
          gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          if (gap_len > 0) pause_sender(gap_len);
          burst_left = $urandom_range(1, 32);
        end
      end
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    // Wind down and give the verdict
    drain_results();
    repeat (8) @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(CLK_PERIOD * 400000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
